>>> hdl/mpd_pkg.sv
// Shared types and constants of the min-pooling image downscaler.
`timescale 1ns / 1ps
`default_nettype none

package mpd_pkg;

  // Default sizing of the line store and the block edge
  localparam int DEF_MAX_WIDTH = 4096;
  localparam int DEF_MAX_SCALE = 16;

  // Register file
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int SCALE_W    = 5;
  localparam int WIDTH_W    = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'b1;

  localparam int SCALE_RESET = 2;
  localparam int WIDTH_RESET = 4096;

  // Payload widths
  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam logic [COORD_W-1:0] COORD_MAX = '1;

  // Result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
  localparam logic [QUEUE_CNT_W-1:0] QUEUE_LIMIT = QUEUE_CNT_W'(QUEUE_DEPTH - 1);

  typedef struct packed {
    logic [PIX_W-1:0]   min_value;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
    logic               end_of_row;
  } mpd_result_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_MUL
  } mpd_div_state_e;

endpackage

`default_nettype wire

>>> hdl/mpd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mpd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/mpd_div.sv
// Bit-serial divider that derives blocks per row and used row length from the registers.
`timescale 1ns / 1ps
`default_nettype none

module mpd_div
  import mpd_pkg::*;
#(
  parameter int WW = 13,
  parameter int SW = 5
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [WW-1:0] dividend_i,
  input  wire logic [SW-1:0] divisor_i,
  output logic               busy_o,
  output logic      [WW-1:0] quot_o,
  output logic      [WW-1:0] prod_o
);

  localparam int CNTW = $clog2(WW + 1);

  mpd_div_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [WW-1:0]   quo_q, quo_d;
  logic [WW-1:0]   prod_q, prod_d;
  logic [SW:0]     trial;
  logic            fits;

  assign trial = {rem_q, quo_q[WW-1]};
  assign fits  = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    prod_d  = prod_q;
    if (start_i) begin
      state_d = DIV_RUN;
      cnt_d   = '0;
      rem_d   = '0;
      quo_d   = dividend_i;
    end else begin
      unique case (state_q)
        DIV_IDLE: begin
          state_d = DIV_IDLE;
        end
        DIV_RUN: begin
          // One quotient bit per cycle, dividend shifts out the top
          rem_d = fits ? SW'(trial - {1'b0, divisor_i}) : SW'(trial);
          quo_d = {quo_q[WW-2:0], fits};
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CNTW'(WW - 1)) begin
            state_d = DIV_MUL;
          end
        end
        DIV_MUL: begin
          prod_d  = WW'(quo_q * divisor_i);
          state_d = DIV_IDLE;
        end
        default: begin
          state_d = DIV_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != DIV_IDLE);
  assign quot_o = quo_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

>>> hdl/mpd_queue.sv
// Small result queue that decouples the pooling pipeline from the output stall.
`timescale 1ns / 1ps
`default_nettype none

module mpd_queue
  import mpd_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire mpd_result_t            push_data_i,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output mpd_result_t                 data_o,
  output logic      [QUEUE_CNT_W-1:0] count_o
);

  mpd_result_t              slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]   count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

>>> hdl/min_pool_image_downscaler.sv
// Top level of the min-pooling image downscaler: counters, line store pipeline, ports.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// pixel in  | input     | in_valid_i / in_stall_o   | pixel_value_i, start_of_frame_i
// result    | output    | out_valid_o / out_stall_i | min_value_o, out_col_o, out_row_o,
//           |           |                        | end_of_row_o
// config    | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel request per clock while in_stall_o is low. A result is registered in stage 1
// after the pixel that closes its block and leaves the queue when the output is not stalled.
// After reset and after every register write the block stalls its input while the
// serial divider works out blocks per row; no clearing pass over the line store is needed.
// A four-entry result queue absorbs output stalls; the input stalls once the queue
// plus the result in flight hold three entries, one short of full.

module min_pool_image_downscaler
  import mpd_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // pixel input
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PIX_W-1:0]      pixel_value_i,
  input  wire logic                  start_of_frame_i,
  // result output
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [PIX_W-1:0]      min_value_o,
  output logic      [COORD_W-1:0]    out_col_o,
  output logic      [COORD_W-1:0]    out_row_o,
  output logic                       end_of_row_o,
  // register writes
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Column counter and line store address width, effective width, scale widths
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam int KW = $clog2(MAX_SCALE);

  localparam logic [SW-1:0] ScaleRst =
    SW'((SCALE_RESET > MAX_SCALE) ? MAX_SCALE : SCALE_RESET);
  localparam logic [WW-1:0] WidthRst =
    WW'((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET);

  // ---------------------------------------------------------------------------
  // Registers, held already clamped into range
  // ---------------------------------------------------------------------------
  logic [SW-1:0]      scale_q;
  logic [WW-1:0]      width_q;
  logic               div_start_q;
  logic               cfg_fire;
  logic [SCALE_W-1:0] raw_scale;
  logic [WIDTH_W-1:0] raw_width;
  logic [SW-1:0]      scale_clamped;
  logic [WW-1:0]      width_clamped;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign raw_scale   = cfg_data_i[SCALE_W-1:0];
  assign raw_width   = cfg_data_i[WIDTH_W-1:0];

  always_comb begin
    if (raw_scale == '0) begin
      scale_clamped = SW'(1);
    end else if (32'(raw_scale) > 32'(MAX_SCALE)) begin
      scale_clamped = SW'(MAX_SCALE);
    end else begin
      scale_clamped = SW'(raw_scale);
    end
    if (raw_width == '0) begin
      width_clamped = WW'(1);
    end else if (32'(raw_width) > 32'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = WW'(raw_width);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleRst;
      width_q     <= WidthRst;
      div_start_q <= 1'b1;   // derive the row geometry once after reset
    end else begin
      div_start_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          CFG_BLOCK_SCALE: scale_q <= scale_clamped;
          CFG_IMAGE_WIDTH: width_q <= width_clamped;
          default:         scale_q <= scale_q;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Row geometry: blocks per row and the used part of a row
  // ---------------------------------------------------------------------------
  logic          div_busy;
  logic [WW-1:0] blocks_per_row;
  logic [WW-1:0] used_width;

  mpd_div #(
    .WW (WW),
    .SW (SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (width_q),
    .divisor_i  (scale_q),
    .busy_o     (div_busy),
    .quot_o     (blocks_per_row),
    .prod_o     (used_width)
  );

  // ---------------------------------------------------------------------------
  // Stage 0: raster counters and the running row minimum
  // ---------------------------------------------------------------------------
  logic [CW-1:0]      col_q, col_d;
  logic [KW-1:0]      cib_q, cib_d;
  logic [WW-1:0]      bcol_q, bcol_d;
  logic [KW-1:0]      rib_q, rib_d;
  logic [COORD_W-1:0] brow_q, brow_d;
  logic [PIX_W-1:0]   pmin_q, pmin_d;

  logic               in_fire;
  logic [CW-1:0]      cc;
  logic [KW-1:0]      ck;
  logic [WW-1:0]      bc;
  logic [KW-1:0]      rk;
  logic [COORD_W-1:0] br;
  logic [PIX_W-1:0]   pm;
  logic [PIX_W-1:0]   pix_min;
  logic               in_used;
  logic               ck_last;
  logic               rk_last;
  logic               row_end;
  logic               blk_end;
  logic               last_block;
  logic [CW-1:0]      rd_addr;

  // Start of frame clears the counters before this pixel counts
  assign cc = start_of_frame_i ? '0 : col_q;
  assign ck = start_of_frame_i ? '0 : cib_q;
  assign bc = start_of_frame_i ? '0 : bcol_q;
  assign rk = start_of_frame_i ? '0 : rib_q;
  assign br = start_of_frame_i ? '0 : brow_q;
  assign pm = start_of_frame_i ? '1 : pmin_q;

  assign in_used    = (WW'(cc) < used_width);
  assign pix_min    = (ck == '0 || pixel_value_i < pm) ? pixel_value_i : pm;
  assign ck_last    = ((SW + 1)'(ck) + 1'b1) >= (SW + 1)'(scale_q);
  assign rk_last    = ((SW + 1)'(rk) + 1'b1) >= (SW + 1)'(scale_q);
  assign row_end    = ((WW + 1)'(cc) + 1'b1) >= (WW + 1)'(width_q);
  assign blk_end    = in_used && ck_last;
  assign last_block = ((WW + 1)'(bc) + 1'b1) >= (WW + 1)'(blocks_per_row);
  assign rd_addr    = bc[CW-1:0];   // line store wraps modulo its depth

  always_comb begin
    col_d  = cc + 1'b1;
    cib_d  = ck;
    bcol_d = bc;
    pmin_d = pm;
    rib_d  = rk;
    brow_d = br;
    if (in_used) begin
      if (ck_last) begin
        cib_d  = '0;
        bcol_d = bc + 1'b1;
        pmin_d = '1;
      end else begin
        cib_d  = ck + 1'b1;
        pmin_d = pix_min;
      end
    end
    if (row_end) begin
      col_d  = '0;
      cib_d  = '0;
      bcol_d = '0;
      pmin_d = '1;
      if (rk_last) begin
        rib_d = '0;
        if (br != COORD_MAX) begin
          brow_d = br + 1'b1;   // saturate the band row
        end
      end else begin
        rib_d = rk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      cib_q  <= '0;
      bcol_q <= '0;
      rib_q  <= '0;
      brow_q <= '0;
      pmin_q <= '1;
    end else if (in_fire) begin
      col_q  <= col_d;
      cib_q  <= cib_d;
      bcol_q <= bcol_d;
      rib_q  <= rib_d;
      brow_q <= brow_d;
      pmin_q <= pmin_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: merge with the line store entry and write it back
  // ---------------------------------------------------------------------------
  logic               s1_valid_q;
  logic               s1_first_q;
  logic               s1_out_q;
  logic [CW-1:0]      s1_addr_q;
  logic [PIX_W-1:0]   s1_min_q;
  logic [COORD_W-1:0] s1_col_q;
  logic [COORD_W-1:0] s1_row_q;
  logic               s1_eor_q;
  logic               fwd_q;
  logic [PIX_W-1:0]   fwd_data_q;
  logic [PIX_W-1:0]   ram_rdata;
  logic [PIX_W-1:0]   line_val;
  logic [PIX_W-1:0]   s1_merged;
  logic               rd_en;

  assign rd_en = in_fire && blk_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= rd_en;
      // Same entry written by stage 1 now: take its new value, not the RAM's
      fwd_q      <= rd_en && s1_valid_q && (s1_addr_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= s1_merged;
    if (rd_en) begin
      s1_first_q <= (rk == '0);
      s1_out_q   <= rk_last;
      s1_addr_q  <= rd_addr;
      s1_min_q   <= pix_min;
      s1_col_q   <= COORD_W'(bc);
      s1_row_q   <= br;
      s1_eor_q   <= last_block;
    end
  end

  mpd_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_merged),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign line_val  = fwd_q ? fwd_data_q : ram_rdata;
  // First row of a band starts the entry fresh; later rows keep the smaller
  assign s1_merged = (s1_first_q || s1_min_q < line_val) ? s1_min_q : line_val;

  // ---------------------------------------------------------------------------
  // Result queue and handshakes
  // ---------------------------------------------------------------------------
  mpd_result_t            push_data;
  mpd_result_t            head;
  logic                   push;
  logic                   pop;
  logic [QUEUE_CNT_W-1:0] q_count;
  logic [QUEUE_CNT_W:0]   q_load;

  assign push = s1_valid_q && s1_out_q;
  assign push_data.min_value  = s1_merged;
  assign push_data.out_col    = s1_col_q;
  assign push_data.out_row    = s1_row_q;
  assign push_data.end_of_row = s1_eor_q;

  mpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (q_count)
  );

  assign pop = out_valid_o && !out_stall_i;

  // Hold input while geometry is recomputed or the queue could overflow
  assign q_load     = (QUEUE_CNT_W + 1)'(q_count) + (QUEUE_CNT_W + 1)'(push);
  assign in_stall_o = div_busy || div_start_q || (q_load >= (QUEUE_CNT_W + 1)'(QUEUE_LIMIT));
  assign in_fire    = in_valid_i && !in_stall_o;

  assign min_value_o  = head.min_value;
  assign out_col_o    = head.out_col;
  assign out_row_o    = head.out_row;
  assign end_of_row_o = head.end_of_row;

endmodule

`default_nettype wire
